// ===== src/jbac_pkg.sv =====
// shared types and constants for the jitter buffer adaptation controller
`timescale 1ns / 1ps
`default_nettype none

package jbac_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 20;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FILL_MIN        = 3'd0,
        CFG_FILL_MAX        = 3'd1,
        CFG_WAIT_MIN_MS     = 3'd2,
        CFG_WAIT_MAX_MS     = 3'd3,
        CFG_FRAME_US        = 3'd4,
        CFG_JITTER_LIMIT_US = 3'd5,
        CFG_GUARD_SECONDS   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  fill_min;
        logic [7:0]  fill_max;
        logic [7:0]  wait_min_ms;
        logic [7:0]  wait_max_ms;
        logic [15:0] frame_us;
        logic [19:0] jitter_limit_us;
        logic [7:0]  guard_seconds;
    } t_cfg;

    localparam logic [7:0]  FillMinRst       = 8'd2;
    localparam logic [7:0]  FillMaxRst       = 8'd8;
    localparam logic [7:0]  WaitMinRst       = 8'd4;
    localparam logic [7:0]  WaitMaxRst       = 8'd20;
    localparam logic [15:0] FrameUsRst       = 16'd10000;
    localparam logic [19:0] JitterLimitUsRst = 20'd15000;
    localparam logic [7:0]  GuardSecondsRst  = 8'd5;

    // one tick of statistics
    typedef struct packed {
        logic [9:0]  concealed_count;
        logic [9:0]  dropped_count;
        logic [7:0]  queue_fill;
        logic [20:0] playout_error_us;
        logic [19:0] jitter_meas_us;
        logic        burst_seen;
    } t_in_item;

    // decisions of the level rules that the offset path needs
    typedef struct packed {
        logic       burst;
        logic       pull_in;
        logic       quiet;
        logic [7:0] nt_mid;
    } t_step_ctrl;

    // phase error thresholds
    localparam logic signed [20:0] PullInErrUs  = 21'sd8000;
    localparam logic signed [20:0] BacklogErrUs = 21'sd2000;
    localparam logic signed [20:0] StuckErrUs   = 21'sd22000;
    localparam logic signed [20:0] QuietPosUs   = 21'sd3000;
    localparam logic signed [20:0] QuietNegUs   = -21'sd3000;

    // correction terms
    localparam logic [16:0] PullInBiasUs  = 17'd2000;
    localparam logic [16:0] StepCapUs     = 17'd9000;
    localparam logic [16:0] FrameSlackUs  = 17'd4000;
    localparam logic [18:0] BacklogUsStep = 19'd1800;
    localparam logic [16:0] QuietPosCapUs = 17'd1500;
    localparam logic [16:0] QuietNegCapUs = 17'd1000;

    localparam logic [1:0]  StuckLimit    = 2'd3;

endpackage

`default_nettype wire

// ===== src/jitter_buffer_adaptation_controller_unit.sv =====
// top level of the jitter buffer adaptation controller
`timescale 1ns / 1ps
`default_nettype none

// Once-per-second adaptation step for an audio jitter buffer. Each request on the input
// stream carries one second of statistics and yields exactly one result carrying the new
// target fill, packet wait, accumulated clock offset and the burst and resync flags. The
// block sustains one request per clock unless results stall: a request sits in an input
// register while the rule logic and the offset adder update the state, and the result is
// registered at the output; the state update loop sets the rate. That output register
// decouples the two sides, so a stalled result holds back at most one more request. The
// user must write registers through the cfg channel (0 fill_min, 1 fill_max, 2 wait_min_ms,
// 3 wait_max_ms, 4 frame_us, 5 jitter_limit_us, 6 guard_seconds) only while the block is
// idle, which it does not enforce; other indexes are ignored; a write never disturbs the state.
module jitter_buffer_adaptation_controller_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // statistics stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // concealed_count, dropped_count, queue_fill, playout_error_us, jitter_meas_us, zero pad
    input  wire logic [71:0]                   i_s_axis_tdata,
    // burst_seen
    input  wire logic [0:0]                    i_s_axis_tuser,
    // result stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // target_fill, packet_wait_ms, offset_corr_us
    output logic [47:0]                        o_m_axis_tdata,
    // resync_request, burst_active
    output logic [1:0]                         o_m_axis_tuser,
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [jbac_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [jbac_pkg::CfgDataW-1:0] i_cfg_data
);
    import jbac_pkg::*;

    t_cfg       w_cfg;
    t_in_item   w_in_item;
    t_step_ctrl w_ctrl;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    logic [47:0] r_out_data;
    logic [1:0] r_out_user;

    logic [7:0]  r_target_level, n_target_level;
    logic [7:0]  r_wait_level,   n_wait_level;
    logic [31:0] r_offset_accum, n_offset_accum;
    logic [7:0]  r_guard_left,   n_guard_left;
    logic [1:0]  r_stuck_count,  n_stuck_count;
    logic        w_resync;

    logic w_out_free;
    logic w_step_fire;
    logic w_in_accept;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_step_fire     = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    always_comb begin
        w_in_item.concealed_count  = i_s_axis_tdata[9:0];
        w_in_item.dropped_count    = i_s_axis_tdata[19:10];
        w_in_item.queue_fill       = i_s_axis_tdata[27:20];
        w_in_item.playout_error_us = i_s_axis_tdata[48:28];
        w_in_item.jitter_meas_us   = i_s_axis_tdata[68:49];
        w_in_item.burst_seen       = i_s_axis_tuser[0];
    end

    jbac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    jbac_level_rules u_levels (
        .i_cfg          (w_cfg),
        .i_item         (r_in_item),
        .i_target_level (r_target_level),
        .i_wait_level   (r_wait_level),
        .i_guard_left   (r_guard_left),
        .i_stuck_count  (r_stuck_count),
        .o_ctrl         (w_ctrl),
        .o_target_next  (n_target_level),
        .o_wait_next    (n_wait_level),
        .o_guard_next   (n_guard_left),
        .o_stuck_next   (n_stuck_count),
        .o_resync       (w_resync)
    );

    jbac_offset_calc u_offset (
        .i_frame_us    (w_cfg.frame_us),
        .i_item        (r_in_item),
        .i_ctrl        (w_ctrl),
        .i_offset      (r_offset_accum),
        .o_offset_next (n_offset_accum)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_target_level <= FillMinRst;
            r_wait_level   <= WaitMinRst;
            r_offset_accum <= 32'd0;
            r_guard_left   <= 8'd0;
            r_stuck_count  <= 2'd0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step_fire) begin
                r_in_valid <= 1'b0;
            end

            if (w_step_fire) begin
                r_out_valid    <= 1'b1;
                r_target_level <= n_target_level;
                r_wait_level   <= n_wait_level;
                r_offset_accum <= n_offset_accum;
                r_guard_left   <= n_guard_left;
                r_stuck_count  <= n_stuck_count;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item <= w_in_item;
        end
        if (w_step_fire) begin
            r_out_data <= {n_offset_accum, n_wait_level, n_target_level};
            r_out_user <= {w_ctrl.burst, w_resync};
        end
    end

    a_stuck_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuck_count != StuckLimit)
        else $error("stuck counter reached its limit in the register");

    a_resync_clears_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_fire && w_resync |=> r_stuck_count == 2'd0)
        else $error("resync request did not clear the stuck counter");

    a_guard_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_fire && !r_in_item.burst_seen && r_guard_left != 8'd0
        |=> r_guard_left == $past(r_guard_left) - 8'd1)
        else $error("burst guard did not count down");

    a_pending_request_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step_fire |=> r_in_valid && $stable(r_in_item))
        else $error("pending request lost or overwritten");

endmodule

`default_nettype wire

// ===== src/jbac_cfg_regs.sv =====
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module jbac_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [jbac_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [jbac_pkg::CfgDataW-1:0] i_cfg_data,
    output jbac_pkg::t_cfg                    o_cfg
);
    import jbac_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fill_min        <= FillMinRst;
            r_cfg.fill_max        <= FillMaxRst;
            r_cfg.wait_min_ms     <= WaitMinRst;
            r_cfg.wait_max_ms     <= WaitMaxRst;
            r_cfg.frame_us        <= FrameUsRst;
            r_cfg.jitter_limit_us <= JitterLimitUsRst;
            r_cfg.guard_seconds   <= GuardSecondsRst;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FILL_MIN:        r_cfg.fill_min        <= i_cfg_data[7:0];
                CFG_FILL_MAX:        r_cfg.fill_max        <= i_cfg_data[7:0];
                CFG_WAIT_MIN_MS:     r_cfg.wait_min_ms     <= i_cfg_data[7:0];
                CFG_WAIT_MAX_MS:     r_cfg.wait_max_ms     <= i_cfg_data[7:0];
                CFG_FRAME_US:        r_cfg.frame_us        <= i_cfg_data[15:0];
                CFG_JITTER_LIMIT_US: r_cfg.jitter_limit_us <= i_cfg_data[19:0];
                CFG_GUARD_SECONDS:   r_cfg.guard_seconds   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/jbac_level_rules.sv =====
// burst mode, fill and wait level rules, guard countdown and stuck detection
`timescale 1ns / 1ps
`default_nettype none

module jbac_level_rules (
    input  jbac_pkg::t_cfg       i_cfg,
    input  jbac_pkg::t_in_item   i_item,
    input  wire logic [7:0]      i_target_level,
    input  wire logic [7:0]      i_wait_level,
    input  wire logic [7:0]      i_guard_left,
    input  wire logic [1:0]      i_stuck_count,
    output jbac_pkg::t_step_ctrl o_ctrl,
    output logic [7:0]           o_target_next,
    output logic [7:0]           o_wait_next,
    output logic [7:0]           o_guard_next,
    output logic [1:0]           o_stuck_next,
    output logic                 o_resync
);
    import jbac_pkg::*;

    logic signed [20:0] err;
    logic [7:0]  guard_eff;
    logic        burst;
    logic        pull_in;
    logic        quiet;
    logic        stuck_cond;
    logic [7:0]  nt0, nt1, nt2, nt3;
    logic [7:0]  nw0, nw1, nw2, nw3;
    logic [8:0]  wait_grow;
    logic [1:0]  stuck1;

    always_comb begin
        err = i_item.playout_error_us;

        // a burst flag reloads the guard before burst mode is decided
        guard_eff = i_item.burst_seen ? i_cfg.guard_seconds : i_guard_left;
        burst     = (guard_eff != 8'd0) || (i_item.jitter_meas_us >= i_cfg.jitter_limit_us);
        o_guard_next = (guard_eff != 8'd0) ? guard_eff - 8'd1 : 8'd0;

        nt0 = burst ? i_cfg.fill_max    : i_target_level;
        nw0 = burst ? i_cfg.wait_max_ms : i_wait_level;

        // growth on heavy concealment, shrink on a clean second with backlog
        nt1 = nt0;
        nw1 = nw0;
        wait_grow = {1'b0, nw0} + 9'd2;
        if (!burst && i_item.concealed_count >= 10'd4) begin
            if (nt0 < i_cfg.fill_max) begin
                nt1 = nt0 + 8'd1;
            end
            if (nw0 < i_cfg.wait_max_ms) begin
                nw1 = wait_grow[8] ? 8'hFF : wait_grow[7:0];
            end
        end else if (!burst && i_item.concealed_count == 10'd0
                     && {1'b0, i_item.queue_fill} >= {1'b0, nt0} + 9'd1) begin
            if (nt0 > i_cfg.fill_min) begin
                nt1 = nt0 - 8'd1;
            end
            if (nw0 > i_cfg.wait_min_ms) begin
                nw1 = nw0 - 8'd1;
            end
        end

        // large lag with a queue: fall back to the minimum levels
        pull_in = (err > PullInErrUs)
                  && ({1'b0, i_item.queue_fill} > {1'b0, i_cfg.fill_min} + 9'd1);
        nt2 = pull_in ? i_cfg.fill_min    : nt1;
        nw2 = pull_in ? i_cfg.wait_min_ms : nw1;

        // stuck-high detection
        stuck_cond = (err > StuckErrUs)
                     && ({2'b0, i_item.queue_fill} >= {2'b0, i_cfg.fill_min} + 10'd3)
                     && (i_item.concealed_count == 10'd0);
        if (!stuck_cond) begin
            stuck1 = 2'd0;
        end else if (i_stuck_count < StuckLimit) begin
            stuck1 = i_stuck_count + 2'd1;
        end else begin
            stuck1 = i_stuck_count;
        end
        o_resync     = (stuck1 == StuckLimit);
        o_stuck_next = o_resync ? 2'd0 : stuck1;

        // quiet second: trim levels when the queue has drained to target
        quiet = !burst && (i_item.concealed_count == 10'd0)
                && (i_item.dropped_count == 10'd0);
        nt3 = nt2;
        nw3 = nw2;
        if (quiet) begin
            if (i_item.queue_fill <= nt2 && nt2 > i_cfg.fill_min) begin
                nt3 = nt2 - 8'd1;
            end
            if (i_item.queue_fill <= nt3 && nw2 > i_cfg.wait_min_ms) begin
                nw3 = nw2 - 8'd1;
            end
        end

        o_target_next  = nt3;
        o_wait_next    = nw3;
        o_ctrl.burst   = burst;
        o_ctrl.pull_in = pull_in;
        o_ctrl.quiet   = quiet;
        o_ctrl.nt_mid  = nt2;
    end

endmodule

`default_nettype wire

// ===== src/jbac_offset_calc.sv =====
// clock offset corrections and saturating accumulate
`timescale 1ns / 1ps
`default_nettype none

module jbac_offset_calc (
    input  wire logic [15:0]     i_frame_us,
    input  jbac_pkg::t_in_item   i_item,
    input  jbac_pkg::t_step_ctrl i_ctrl,
    input  wire logic [31:0]     i_offset,
    output logic [31:0]          o_offset_next
);
    import jbac_pkg::*;

    // floor(x / 3) for x below 2^15, reciprocal multiply
    function automatic logic [13:0] div3_u15(input logic [14:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd43691;
        return p[30:17];
    endfunction

    // floor(x / 10) for x below 2^15
    function automatic logic [11:0] div10_u15(input logic [14:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd52429;
        return p[30:19];
    endfunction

    logic signed [20:0] err;
    logic signed [20:0] half_frame;
    logic [20:0] mag;
    logic [14:0] mag15;
    logic [13:0] q3;
    logic [11:0] q10;
    logic [15:0] pull_sum;
    logic [16:0] c1, c2, c3, c4p, c4n;
    logic [16:0] frame_cap, c2a;
    logic [25:0] drop_prod;
    logic [7:0]  backlog;
    logic [18:0] backlog_us;
    logic [19:0] s3;
    logic [17:0] pos_sum;
    logic signed [18:0] corr;
    logic signed [33:0] acc;

    always_comb begin
        err        = i_item.playout_error_us;
        half_frame = {6'b0, i_frame_us[15:1]};
        mag        = err[20] ? 21'(-err) : err;
        // every divided term is capped well below what 15 bits can give
        mag15      = (mag > 21'd32767) ? 15'h7FFF : mag[14:0];
        q3         = div3_u15(mag15);
        q10        = div10_u15(mag15);

        // pull-in correction
        pull_sum = {1'b0, mag15[14:1]} + PullInBiasUs[15:0];
        c1 = 17'd0;
        if (i_ctrl.pull_in) begin
            c1 = ({1'b0, pull_sum} > StepCapUs) ? StepCapUs : {1'b0, pull_sum};
        end

        // concealment correction, limited by one frame plus slack and by the error
        drop_prod = 26'(i_item.concealed_count) * 26'(i_frame_us);
        frame_cap = {1'b0, i_frame_us} + FrameSlackUs;
        c2a = (drop_prod > 26'(frame_cap)) ? frame_cap : drop_prod[16:0];
        c2  = 17'd0;
        if (!i_ctrl.burst && i_item.concealed_count != 10'd0 && err > half_frame) begin
            c2 = (21'(c2a) > mag) ? mag[16:0] : c2a;
        end

        // backlog correction
        backlog    = i_item.queue_fill - i_ctrl.nt_mid;
        backlog_us = 19'(backlog) * BacklogUsStep;
        s3 = 20'(backlog_us) + 20'(q3);
        c3 = 17'd0;
        if (i_item.queue_fill > i_ctrl.nt_mid && err > BacklogErrUs) begin
            c3 = (s3 > 20'(StepCapUs)) ? StepCapUs : s3[16:0];
        end

        // fine trim on a quiet second
        c4p = 17'd0;
        c4n = 17'd0;
        if (i_ctrl.quiet && err > QuietPosUs) begin
            c4p = (17'(q3[13:1]) > QuietPosCapUs) ? QuietPosCapUs : 17'(q3[13:1]);
        end
        if (i_ctrl.quiet && err < QuietNegUs) begin
            c4n = (17'(q10) > QuietNegCapUs) ? QuietNegCapUs : 17'(q10);
        end

        // all terms of one step share a sign, so clamping the total once
        // matches clamping after every term
        pos_sum = 18'(c1) + 18'(c2) + 18'(c3) + 18'(c4p);
        corr    = (c4n != 17'd0) ? -$signed({2'b0, c4n}) : $signed({1'b0, pos_sum});
        acc     = $signed({{2{i_offset[31]}}, i_offset}) + 34'(corr);

        if (acc[33:31] == 3'b000 || acc[33:31] == 3'b111) begin
            o_offset_next = acc[31:0];
        end else if (acc[33]) begin
            o_offset_next = 32'h8000_0000;
        end else begin
            o_offset_next = 32'h7FFF_FFFF;
        end
    end

endmodule

`default_nettype wire
